// ===== rtl/nal_ep_pkg.sv =====
// Types and constants for the NAL unit builder with emulation prevention.
package nal_ep_pkg;

  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned BITS_W     = 27;
  localparam int unsigned WIDE_W     = 40;

  localparam logic [7:0]        ESC_BYTE  = 8'h03;
  localparam logic [7:0]        HDR_TAIL  = 8'h01;
  localparam logic [BITS_W-1:0] BITS_MAX  = 27'd134217720;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_NOHDR   = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_EXTRA   = 2'd3
  } kind_e;

  // One input beat held in the input register.
  typedef struct packed {
    kind_e      kind;
    logic [5:0] nal_type;
    logic [7:0] data_byte;
    logic       end_sub;
    logic       end_unit;
  } item_t;

  // One output beat waiting in the result buffer.
  typedef struct packed {
    logic [7:0]        out_byte;
    logic              last;
    logic              done;
    logic              sv;
    logic [BITS_W-1:0] bits;
  } res_t;

endpackage

// ===== rtl/nal_emulation_prevention_core.sv =====
// NAL unit builder: header insertion, emulation prevention and sub-stream length report.
// The first output beat of an input beat passes the input register, then the result buffer,
//   before it can be taken. One input beat is taken per cycle while each beat yields one
//   output beat and the output is not stalled; a beat yielding more than one output beat
//   holds back the next beat until the result buffer, which drains one beat per cycle
//   unless the output is stalled, has drained them all.
// Reset (rst_ni low, asynchronous): both registers empty, zero run, header mode,
//   last-zero flag and sub-stream byte count cleared.
module nal_emulation_prevention_core
  import nal_ep_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        kind_i,
  input  logic [5:0]        nal_type_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_substream_i,
  input  logic              end_of_unit_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o,
  output logic              unit_done_o,
  output logic              substream_valid_o,
  output logic [BITS_W-1:0] substream_bits_o
);

  // Input register: holds the next beat while the result buffer drains.
  logic  item_vld_q, item_vld_d;
  item_t item_q, item_d;

  // Escaping state, updated when a beat moves into the result buffer.
  logic [1:0]            zr_q, zr_d;
  logic                  hm_q, hm_d;
  logic                  loz_q, loz_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  // Result buffer: up to three output beats per input beat.
  res_t       buf_q [3];
  res_t       buf_d [3];
  logic [1:0] num_q, num_d;
  logic [1:0] idx_q, idx_d;

  logic       in_fire, out_fire, drain_last, take;
  logic [1:0] n;
  res_t       res [3];
  res_t       cur;

  // Combinational work on one beat.
  logic                  esc;
  logic [COUNT_BITS:0]   cnt_ext;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [WIDE_W-1:0]     bits_wide;
  logic [BITS_W-1:0]     bits_sat;
  logic                  is_start;

  // ---------------------------------------------------------------------------
  // Handshake: the input register is free when empty or when its beat moves on.
  // ---------------------------------------------------------------------------
  always_comb begin
    case (idx_q)
      2'd0:    cur = buf_q[0];
      2'd1:    cur = buf_q[1];
      2'd2:    cur = buf_q[2];
      default: cur = '0;
    endcase
  end

  assign out_valid_o = (num_q != 2'd0);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign drain_last  = out_fire && (idx_q == (num_q - 2'd1));
  assign take        = item_vld_q && ((num_q == 2'd0) || drain_last);
  assign in_stall_o  = item_vld_q && !take;
  assign in_fire     = in_valid_i && !in_stall_o;

  assign out_byte_o        = cur.out_byte;
  assign last_of_run_o     = cur.last;
  assign unit_done_o       = cur.done;
  assign substream_valid_o = cur.sv;
  assign substream_bits_o  = cur.bits;

  always_comb begin
    item_vld_d = item_vld_q;
    item_d     = item_q;
    if (in_fire) begin
      item_vld_d = 1'b1;
      item_d     = '{kind: kind_e'(kind_i), nal_type: nal_type_i,
                     data_byte: data_byte_i, end_sub: end_of_substream_i,
                     end_unit: end_of_unit_i};
    end else if (take) begin
      item_vld_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Beat processing: builds the output beats and the next escaping state.
  // ---------------------------------------------------------------------------
  always_comb begin
    zr_d     = zr_q;
    hm_d     = hm_q;
    loz_d    = loz_q;
    cnt_d    = cnt_q;
    n        = 2'd0;
    res[0]   = '0;
    res[1]   = '0;
    res[2]   = '0;
    is_start = 1'b0;

    // Escape when two zeros were emitted and the payload byte is 0x03 or less.
    esc       = (zr_q == 2'd2) && (item_q.data_byte <= ESC_BYTE);
    cnt_ext   = {1'b0, cnt_q} + (esc ? (COUNT_BITS+1)'(2) : (COUNT_BITS+1)'(1));
    cnt_new   = (cnt_ext > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_ext[COUNT_BITS-1:0];
    bits_wide = WIDE_W'(cnt_new) << 3;
    bits_sat  = (bits_wide > WIDE_W'(BITS_MAX)) ? BITS_MAX : bits_wide[BITS_W-1:0];

    case (item_q.kind)
      KIND_HDR: begin
        // Header ends in 0x01, so zero tracking ends cleared.
        is_start        = 1'b1;
        zr_d            = 2'd0;
        loz_d           = 1'b0;
        cnt_d           = '0;
        hm_d            = 1'b1;
        res[0].out_byte = {1'b0, item_q.nal_type, 1'b0};
        res[1].out_byte = HDR_TAIL;
        n               = 2'd2;
      end
      KIND_NOHDR: begin
        is_start = 1'b1;
        zr_d     = 2'd0;
        loz_d    = 1'b0;
        cnt_d    = '0;
        hm_d     = 1'b0;
      end
      KIND_PAYLOAD: begin
        cnt_d = item_q.end_sub ? '0 : cnt_new;
        if (item_q.data_byte == 8'h00) begin
          zr_d = esc ? 2'd1 : ((zr_q == 2'd2) ? 2'd2 : zr_q + 2'd1);
        end else begin
          zr_d = 2'd0;
        end
        loz_d = (item_q.data_byte == 8'h00);
        if (esc) begin
          res[0].out_byte = ESC_BYTE;
          res[1].out_byte = item_q.data_byte;
          res[1].sv       = item_q.end_sub;
          res[1].bits     = item_q.end_sub ? bits_sat : '0;
          n               = 2'd2;
        end else begin
          res[0].out_byte = item_q.data_byte;
          res[0].sv       = item_q.end_sub;
          res[0].bits     = item_q.end_sub ? bits_sat : '0;
          n               = 2'd1;
        end
      end
      KIND_EXTRA: begin
        // Copied unescaped, but still counts toward the zero run.
        if (item_q.data_byte == 8'h00) begin
          zr_d = (zr_q == 2'd2) ? 2'd2 : zr_q + 2'd1;
        end else begin
          zr_d = 2'd0;
        end
        loz_d           = (item_q.data_byte == 8'h00);
        res[0].out_byte = item_q.data_byte;
        n               = 2'd1;
      end
      default: ;
    endcase

    // Trailing 0x03 for a headered unit that ends on a zero byte.
    if (item_q.end_unit && !is_start && hm_d && loz_d) begin
      zr_d  = 2'd0;
      loz_d = 1'b0;
      case (n)
        2'd1:    res[1].out_byte = ESC_BYTE;
        2'd2:    res[2].out_byte = ESC_BYTE;
        default: ;
      endcase
      n = n + 2'd1;
    end

    case (n)
      2'd1: begin
        res[0].last = 1'b1;
        res[0].done = item_q.end_unit;
      end
      2'd2: begin
        res[1].last = 1'b1;
        res[1].done = item_q.end_unit;
      end
      2'd3: begin
        res[2].last = 1'b1;
        res[2].done = item_q.end_unit;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result buffer control.
  // ---------------------------------------------------------------------------
  always_comb begin
    buf_d[0] = buf_q[0];
    buf_d[1] = buf_q[1];
    buf_d[2] = buf_q[2];
    num_d    = num_q;
    idx_d    = idx_q;
    if (take) begin
      buf_d[0] = res[0];
      buf_d[1] = res[1];
      buf_d[2] = res[2];
      num_d    = n;
      idx_d    = 2'd0;
    end else if (drain_last) begin
      num_d = 2'd0;
      idx_d = 2'd0;
    end else if (out_fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      zr_q       <= 2'd0;
      hm_q       <= 1'b0;
      loz_q      <= 1'b0;
      cnt_q      <= '0;
      num_q      <= 2'd0;
      idx_q      <= 2'd0;
    end else begin
      item_vld_q <= item_vld_d;
      num_q      <= num_d;
      idx_q      <= idx_d;
      if (take) begin
        zr_q  <= zr_d;
        hm_q  <= hm_d;
        loz_q <= loz_d;
        cnt_q <= cnt_d;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    buf_q[0] <= buf_d[0];
    buf_q[1] <= buf_d[1];
    buf_q[2] <= buf_d[2];
  end

endmodule
